// ===== sv/nonuniform_grid_bilinear_interp_assert.svh =====
// Assertion macros for the nonuniform grid interpolator.
// Used by the top level; no other dependencies.
`ifndef NONUNIFORM_GRID_BILINEAR_INTERP_ASSERT_SVH
`define NONUNIFORM_GRID_BILINEAR_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
`define NGBI_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define NGBI_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define NGBI_ASSERT_IMPL(label, clk, rst_n, prop)
`define NGBI_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/ngbi_pkg.sv =====
// Shared types and constants for the nonuniform grid interpolator.
// No dependencies.
package ngbi_pkg;
    localparam int MAX_COS_POINTS_DEF    = 32;
    localparam int MAX_ENERGY_POINTS_DEF = 64;
    localparam int CW  = 16;
    localparam int EW  = 18;
    localparam int VW  = 32;
    localparam int IW  = 11;

    localparam logic [1:0] OP_WR_COS    = 2'd0;
    localparam logic [1:0] OP_WR_ENERGY = 2'd1;
    localparam logic [1:0] OP_WR_GRID   = 2'd2;
    localparam logic [1:0] OP_EVAL      = 2'd3;

    localparam logic CFG_COS_USED    = 1'b0;
    localparam logic CFG_ENERGY_USED = 1'b1;

    // datapath micro-steps selected by the controller
    typedef enum logic [3:0] {
        DP_NONE   = 4'd0,
        DP_LOAD   = 4'd1,  // latch query, issue edge reads
        DP_RANGE  = 4'd2,  // range test on edge points
        DP_CSCAN  = 4'd3,  // one cosine scan step
        DP_ESCAN  = 4'd4,  // one energy scan step
        DP_PREP0  = 4'd5,  // read grid nodes, latch bracket points
        DP_PREP1  = 4'd6,  // take last grid node
        DP_MUL    = 4'd7,  // multiply step
        DP_DIVST  = 4'd8,  // load divider
        DP_DIV    = 4'd9,  // one divider step
        DP_DIVEND = 4'd10  // take quotient
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        logic [1:0] phase;  // 0 energy row0, 1 energy row1, 2 cosine
    } dp_cmd_t;

    typedef struct packed {
        logic in_range;
        logic cscan_done;
        logic escan_done;
        logic div_done;
        logic degen;
    } dp_stat_t;
endpackage

// ===== sv/nonuniform_grid_bilinear_interp.sv =====
// Top level of the nonuniform grid bilinear interpolator.
// Depends on ngbi_pkg, ngbi_ctrl, ngbi_datapath and the assertion header.
//
// Usage: raise start with operation and payload while busy is low; the item
// is taken at that edge. Operations 0..2 load a cosine point, an energy point
// or a grid node value; operation 3 evaluates at (cosine, log_energy).
// Every item yields exactly one result: half_area and in_range appear for one
// cycle while done is high. The receiver cannot stall, so it must sample then.
// An out-of-range evaluate ends after the range test. An in-range evaluate
// scans the cosine axis in nc-1 steps, then the energy axis, reads four grid
// nodes from the node memory, and runs three interpolations, each of
// 3 multiply steps, a divider load, 53 restoring steps and a take.
// The serial divider dominates the run time from accept through done.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while idle;
// the block itself does not enforce this.
// Reset clears the control and restores both point counts to their maxima;
// the point and node memories are undefined until written.
`include "nonuniform_grid_bilinear_interp_assert.svh"
module nonuniform_grid_bilinear_interp #(
    parameter int MAX_COS_POINTS    = ngbi_pkg::MAX_COS_POINTS_DEF,
    parameter int MAX_ENERGY_POINTS = ngbi_pkg::MAX_ENERGY_POINTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    done,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [6:0]              cfg_data,
    input  logic [1:0]              operation,
    input  logic [ngbi_pkg::IW-1:0] write_index,
    input  logic signed [ngbi_pkg::CW-1:0] cosine,
    input  logic [ngbi_pkg::EW-1:0] log_energy,
    input  logic [ngbi_pkg::VW-1:0] area_value,
    output logic [ngbi_pkg::VW-1:0] half_area,
    output logic                    in_range
);
    import ngbi_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     start_acc;
    logic     eval_out;
    logic [VW-1:0] result;

    ngbi_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .operation      (operation),
        .stat           (stat),
        .cmd            (cmd),
        .busy           (busy),
        .start_acc      (start_acc),
        .done           (done),
        .out_valid_eval (eval_out)
    );

    ngbi_datapath #(
        .MAX_COS_POINTS    (MAX_COS_POINTS),
        .MAX_ENERGY_POINTS (MAX_ENERGY_POINTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_acc   (start_acc),
        .operation   (operation),
        .write_index (write_index),
        .cosine      (cosine),
        .log_energy  (log_energy),
        .area_value  (area_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .result      (result)
    );

    // results are zero except for a finished in-range evaluate
    assign half_area = eval_out ? result : '0;
    assign in_range  = eval_out;

    `NGBI_ASSERT_IMPL(a_done_idle_next, clk, rst_n, done |=> !busy)
    `NGBI_ASSERT_NEXT(a_acc_busy, clk, rst_n, start_acc, busy)
    `NGBI_ASSERT_IMPL(a_inr_done, clk, rst_n, in_range |-> done)
endmodule

// ===== sv/ngbi_datapath.sv =====
// Datapath: point and grid memories, bracket scan, weighting and serial divider.
// Depends on ngbi_pkg.
module ngbi_datapath #(
    parameter int MAX_COS_POINTS    = ngbi_pkg::MAX_COS_POINTS_DEF,
    parameter int MAX_ENERGY_POINTS = ngbi_pkg::MAX_ENERGY_POINTS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start_acc,
    input  logic [1:0]              operation,
    input  logic [ngbi_pkg::IW-1:0] write_index,
    input  logic signed [ngbi_pkg::CW-1:0] cosine,
    input  logic [ngbi_pkg::EW-1:0] log_energy,
    input  logic [ngbi_pkg::VW-1:0] area_value,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [6:0]              cfg_data,
    input  ngbi_pkg::dp_cmd_t       cmd,
    output ngbi_pkg::dp_stat_t      stat,
    output logic [ngbi_pkg::VW-1:0] result
);
    import ngbi_pkg::*;
    localparam int CIW = (MAX_COS_POINTS > 1) ? $clog2(MAX_COS_POINTS) : 1;
    localparam int EIW = (MAX_ENERGY_POINTS > 1) ? $clog2(MAX_ENERGY_POINTS) : 1;
    localparam int GDEPTH = MAX_COS_POINTS * MAX_ENERGY_POINTS;
    localparam int GIW = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int NCW = CIW + 1;
    localparam int NEW = EIW + 1;
    localparam int DW  = 20;   // span width (signed diff of 18/16 bit points)
    localparam int NW  = VW + DW + 1;
    localparam int DCW = $clog2(NW + 1);

    logic signed [CW-1:0] cos_mem [MAX_COS_POINTS];
    logic [EW-1:0]        en_mem  [MAX_ENERGY_POINTS];
    logic [VW-1:0]        grid_mem [GDEPTH];

    logic [5:0] cos_used_reg;
    logic [6:0] en_used_reg;
    logic [NCW-1:0] nc;
    logic [NEW-1:0] ne;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_used_reg <= 6'd32;
            en_used_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_COS_USED)
                cos_used_reg <= cfg_data[5:0];
            else
                en_used_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (cos_used_reg < 6'd2)
            nc = NCW'(2);
        else if (32'(cos_used_reg) > MAX_COS_POINTS)
            nc = NCW'(MAX_COS_POINTS);
        else
            nc = NCW'(cos_used_reg);
        if (en_used_reg < 7'd2)
            ne = NEW'(2);
        else if (32'(en_used_reg) > MAX_ENERGY_POINTS)
            ne = NEW'(MAX_ENERGY_POINTS);
        else
            ne = NEW'(en_used_reg);
    end

    // writes
    always_ff @(posedge clk)
    begin
        if (start_acc && operation == OP_WR_COS && 32'(write_index) < MAX_COS_POINTS)
            cos_mem[write_index[CIW-1:0]] <= cosine;
    end

    // grid write address is the flat index itself
    logic [GIW-1:0] gw_addr;
    logic           gw_ok;
    assign gw_addr = GIW'(write_index);
    assign gw_ok   = 32'(write_index) < GDEPTH;

    // query registers
    logic signed [CW-1:0] cq_reg;
    logic [EW-1:0]        eq_reg;
    logic [CIW-1:0] ci_reg, ci_next;
    logic [EIW-1:0] ei_reg, ei_next;
    logic signed [CW-1:0] c_lo_reg, c_hi_reg, c_first_reg, c_last_reg;
    logic [EW-1:0]        e_lo_reg, e_hi_reg;
    logic [VW-1:0] y00_reg, y01_reg, y10_reg, y11_reg, a_reg, b_reg;
    logic cfound_reg, efound_reg;
    logic [NCW-1:0] cscan_reg;
    logic [NEW-1:0] escan_reg;
    logic [VW-1:0] grd_reg;
    logic [GIW-1:0] g_addr;
    logic [GIW-1:0] g_base;

    // grid memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (start_acc && operation == OP_WR_GRID && gw_ok)
            grid_mem[gw_addr] <= area_value;
        grd_reg <= grid_mem[g_addr];
    end

    // grid read address sequence in PREP steps
    logic [1:0] gsel_reg;
    assign g_base = GIW'(ci_reg) * GIW'(MAX_ENERGY_POINTS) + GIW'(ei_reg);
    always_comb
    begin
        case (gsel_reg)
            2'd0:    g_addr = g_base;
            2'd1:    g_addr = g_base + GIW'(1);
            2'd2:    g_addr = g_base + GIW'(MAX_ENERGY_POINTS);
            default: g_addr = g_base + GIW'(MAX_ENERGY_POINTS) + GIW'(1);
        endcase
    end

    // scan index next
    logic [CIW-1:0] cs_idx;
    logic [EIW-1:0] es_idx;
    assign cs_idx = cscan_reg[CIW-1:0];
    assign es_idx = escan_reg[EIW-1:0];

    // energy points: two registered reads, addressed in the cycle before their use
    logic [EIW-1:0] ea0, ea1;
    logic [EW-1:0]  er0_reg, er1_reg;
    always_comb
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                ea0 = '0;
                ea1 = ne[EIW-1:0] - EIW'(1);
            end
            DP_ESCAN:
            begin
                ea0 = es_idx + EIW'(1);
                ea1 = es_idx + EIW'(2);
            end
            DP_PREP0:
            begin
                ea0 = ei_reg;
                ea1 = ei_reg + EIW'(1);
            end
            default:
            begin
                ea0 = es_idx;
                ea1 = es_idx + EIW'(1);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start_acc && operation == OP_WR_ENERGY && 32'(write_index) < MAX_ENERGY_POINTS)
            en_mem[write_index[EIW-1:0]] <= log_energy;
        er0_reg <= en_mem[ea0];
        er1_reg <= en_mem[ea1];
    end

    // arithmetic regs
    logic [DW-1:0]  d_reg, t_reg;
    logic           degen_reg;
    logic [NW-1:0]  num_reg;
    logic [NW-1:0]  rem_reg;
    logic [NW-1:0]  quo_reg;
    logic [DW:0]    div_reg;
    logic [DCW-1:0] dcnt_reg;
    logic [1:0]     mstep_reg;
    logic [VW-1:0]  res_reg;
    logic           inr_reg;

    logic signed [DW-1:0] d_s, t_s;
    logic [VW-1:0] ylo, yhi;
    always_comb
    begin
        if (cmd.phase == 2'd2)
        begin
            d_s = DW'(c_hi_reg) - DW'(c_lo_reg);
            t_s = DW'(cq_reg) - DW'(c_lo_reg);
            ylo = a_reg;
            yhi = b_reg;
        end
        else
        begin
            d_s = DW'({2'b00, e_hi_reg}) - DW'({2'b00, e_lo_reg});
            t_s = DW'({2'b00, eq_reg}) - DW'({2'b00, e_lo_reg});
            ylo = (cmd.phase == 2'd0) ? y00_reg : y10_reg;
            yhi = (cmd.phase == 2'd0) ? y01_reg : y11_reg;
        end
    end

    logic [DW+VW-1:0] prod;
    always_comb
    begin
        if (mstep_reg == 2'd1)
            prod = ylo * (d_reg - t_reg);
        else
            prod = yhi * t_reg;
    end

    logic [NW:0] trial;
    assign trial = {rem_reg, num_reg[NW-1]} - {{(NW-DW){1'b0}}, div_reg};

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                cq_reg      <= cosine;
                eq_reg      <= log_energy;
                c_first_reg <= cos_mem[0];
                c_last_reg  <= cos_mem[nc[CIW-1:0] - CIW'(1)];
                cscan_reg   <= '0;
                escan_reg   <= '0;
                cfound_reg  <= 1'b0;
                efound_reg  <= 1'b0;
                ci_reg      <= CIW'(nc - NCW'(2));
                ei_reg      <= EIW'(ne - NEW'(2));
                gsel_reg    <= 2'd0;
            end
            DP_RANGE:
                inr_reg <= !(eq_reg > er1_reg || eq_reg < er0_reg ||
                             cq_reg > c_last_reg || cq_reg < c_first_reg);
            DP_CSCAN:
            begin
                if (!cfound_reg && cq_reg >= cos_mem[cs_idx] &&
                    cq_reg < cos_mem[cs_idx + CIW'(1)])
                begin
                    ci_reg     <= cs_idx;
                    cfound_reg <= 1'b1;
                end
                cscan_reg <= cscan_reg + NCW'(1);
            end
            DP_ESCAN:
            begin
                if (!efound_reg && eq_reg >= er0_reg && eq_reg < er1_reg)
                begin
                    ei_reg     <= es_idx;
                    efound_reg <= 1'b1;
                end
                escan_reg <= escan_reg + NEW'(1);
            end
            DP_PREP0:
            begin
                // grd_reg holds the previous address's word
                case (gsel_reg)
                    2'd1:    y00_reg <= grd_reg;
                    2'd2:    y01_reg <= grd_reg;
                    2'd3:    y10_reg <= grd_reg;
                    default: ;
                endcase
                gsel_reg <= gsel_reg + 2'd1;
                c_lo_reg <= cos_mem[ci_reg];
                c_hi_reg <= cos_mem[ci_reg + CIW'(1)];
                e_lo_reg <= er0_reg;
                e_hi_reg <= er1_reg;
            end
            DP_PREP1:
                y11_reg <= grd_reg;
            DP_MUL:
            begin
                if (mstep_reg == 2'd0)
                begin
                    degen_reg <= d_s <= 0;
                    d_reg <= d_s;
                    t_reg <= (t_s < 0) ? '0 : ((t_s > d_s) ? d_s : t_s);
                    num_reg <= '0;
                end
                else if (mstep_reg == 2'd1)
                    num_reg <= NW'(prod);
                else
                    num_reg <= num_reg + NW'(prod);
            end
            DP_DIVST:
            begin
                if (cmd.phase == 2'd2)
                begin
                    num_reg <= num_reg + NW'(d_reg);
                    div_reg <= {d_reg, 1'b0};
                end
                else
                begin
                    num_reg <= num_reg + NW'(d_reg >> 1);
                    div_reg <= {1'b0, d_reg};
                end
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= DCW'(NW);
            end
            DP_DIV:
            begin
                if (!trial[NW])
                begin
                    rem_reg <= trial[NW-1:0];
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[NW-2:0], num_reg[NW-1]};
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
                num_reg  <= {num_reg[NW-2:0], 1'b0};
                dcnt_reg <= dcnt_reg - DCW'(1);
            end
            DP_DIVEND:
            begin
                case (cmd.phase)
                    2'd0:
                        a_reg <= degen_reg ? y00_reg : quo_reg[VW-1:0];
                    2'd1:
                        b_reg <= degen_reg ? y10_reg : quo_reg[VW-1:0];
                    default:
                        res_reg <= degen_reg ? VW'(({1'b0, a_reg} + 33'd1) >> 1)
                                             : quo_reg[VW-1:0];
                endcase
            end
            default: ;
        endcase
    end

    // mstep sequences the multiply: setup, low term, high term
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mstep_reg <= 2'd0;
        else if (cmd.op == DP_MUL)
            mstep_reg <= (mstep_reg == 2'd2) ? 2'd0 : mstep_reg + 2'd1;
    end

    assign stat.in_range   = inr_reg;
    assign stat.cscan_done = (cscan_reg == nc - NCW'(1));
    assign stat.escan_done = (escan_reg == ne - NEW'(1));
    assign stat.div_done   = (dcnt_reg == DCW'(1));
    assign stat.degen      = degen_reg;
    assign result          = res_reg;
endmodule

// ===== sv/ngbi_ctrl.sv =====
// Controller FSM for the nonuniform grid interpolator.
// Depends on ngbi_pkg.
module ngbi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         operation,
    input  ngbi_pkg::dp_stat_t stat,
    output ngbi_pkg::dp_cmd_t  cmd,
    output logic               busy,
    output logic               start_acc,
    output logic               done,
    output logic               out_valid_eval
);
    import ngbi_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_WDONE = 12'b000000000010,
        S_RANGE = 12'b000000000100,
        S_CSCAN = 12'b000000001000,
        S_ESCAN = 12'b000000010000,
        S_PREP  = 12'b000000100000,
        S_PREP1 = 12'b000001000000,
        S_MUL   = 12'b000010000000,
        S_DIVST = 12'b000100000000,
        S_DIV   = 12'b001000000000,
        S_DEND  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic [1:0] cnt_reg, cnt_next;

    assign busy      = (state_reg != S_IDLE);
    assign start_acc = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd.op     = DP_NONE;
        cmd.phase  = phase_reg;
        done       = 1'b0;
        out_valid_eval = 1'b0;
        case (state_reg)
            S_IDLE:
                if (start_acc)
                begin
                    if (operation == OP_EVAL)
                    begin
                        cmd.op = DP_LOAD;
                        state_next = S_RANGE;
                    end
                    else
                        state_next = S_WDONE;
                end
            S_WDONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            S_RANGE:
            begin
                cmd.op = DP_RANGE;
                state_next = S_CSCAN;
            end
            S_CSCAN:
            begin
                if (!stat.in_range)
                begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op = DP_CSCAN;
                    if (stat.cscan_done)
                    begin
                        cmd.op = DP_NONE;
                        state_next = S_ESCAN;
                    end
                end
            end
            S_ESCAN:
            begin
                cmd.op = DP_ESCAN;
                if (stat.escan_done)
                begin
                    cmd.op = DP_NONE;
                    cnt_next = 2'd0;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op = DP_PREP0;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_PREP1;
            end
            S_PREP1:
            begin
                cmd.op = DP_PREP1;
                phase_next = 2'd0;
                cnt_next = 2'd0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = DP_MUL;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                    state_next = S_DIVST;
            end
            S_DIVST:
            begin
                cmd.op = DP_DIVST;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = DP_DIV;
                if (stat.div_done)
                    state_next = S_DEND;
            end
            S_DEND:
            begin
                cmd.op = DP_DIVEND;
                cnt_next = 2'd0;
                if (phase_reg == 2'd2)
                    state_next = S_OUT;
                else
                begin
                    phase_next = phase_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                done = 1'b1;
                out_valid_eval = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 2'd0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
